FILE: design/jkie_pkg.sv
// ---------------------------------------------------------------------------
// jkie_pkg
// Types, widths, codes and reset values shared by the joystick and key
// input event unit.
// ---------------------------------------------------------------------------
package jkie_pkg;

   // Build-time sizing
   localparam int QUEUE_DEPTH = 16;
   localparam int ADC_BITS    = 12;
   localparam int KEY_COUNT   = 5;

   localparam int DIR_KEYS = 4;                       // up, down, left, right
   localparam int EV_BITS  = DIR_KEYS + KEY_COUNT;    // held/pressed/released
   localparam int DIR_W    = 3;
   localparam int THR_W    = 2 * ADC_BITS;
   localparam int TIME_W   = 32;
   localparam int MS_W     = 16;
   localparam int DEB_W    = 8;
   localparam int INV_W    = 2;
   localparam int PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = THR_W;

   // Request payload layout, lowest bit first: joy_x, joy_y, raw_keys, now_ms
   localparam int REQ_X_LSB    = 0;
   localparam int REQ_Y_LSB    = REQ_X_LSB + ADC_BITS;
   localparam int REQ_KEY_LSB  = REQ_Y_LSB + ADC_BITS;
   localparam int REQ_NOW_LSB  = REQ_KEY_LSB + KEY_COUNT;
   localparam int REQ_BITS     = REQ_NOW_LSB + TIME_W;
   localparam int REQ_DATA_W   = ((REQ_BITS + 7) / 8) * 8;

   // Response payload: direction, held, pressed, released, repeat, count
   localparam int RSP_BITS   = DIR_W + 3 * EV_BITS + DIR_KEYS + CNT_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   // Request kinds
   localparam logic OP_SCAN    = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   // Direction codes
   localparam logic [DIR_W-1:0] DIR_CENTER = 3'd0;
   localparam logic [DIR_W-1:0] DIR_UP     = 3'd1;
   localparam logic [DIR_W-1:0] DIR_DOWN   = 3'd2;
   localparam logic [DIR_W-1:0] DIR_LEFT   = 3'd3;
   localparam logic [DIR_W-1:0] DIR_RIGHT  = 3'd4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_X_ENTER   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_ENTER   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_X_EXIT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_EXIT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RPT_DELAY = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RPT_INTV  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT    = 3'd7;

   // Register reset values
   localparam logic [THR_W-1:0] ENTER_RST     = THR_W'(12289000);
   localparam logic [THR_W-1:0] EXIT_RST      = THR_W'(11060600);
   localparam logic [MS_W-1:0]  RPT_DELAY_RST = MS_W'(400);
   localparam logic [MS_W-1:0]  RPT_INTV_RST  = MS_W'(120);
   localparam logic [DEB_W-1:0] DEBOUNCE_RST  = DEB_W'(3);

   typedef struct packed {
      logic [THR_W-1:0] x_enter;
      logic [THR_W-1:0] y_enter;
      logic [THR_W-1:0] x_exit;
      logic [THR_W-1:0] y_exit;
      logic [MS_W-1:0]  rpt_delay;
      logic [MS_W-1:0]  rpt_interval;
      logic [DEB_W-1:0] debounce;
      logic [INV_W-1:0] invert;
   } cfg_type;

   // One queued event frame; pressed sits in the lowest bits
   typedef struct packed {
      logic [DIR_KEYS-1:0] repeats;
      logic [EV_BITS-1:0]  released;
      logic [EV_BITS-1:0]  pressed;
   } frame_type;

   typedef struct packed {
      logic [DIR_W-1:0]   direction;
      logic [EV_BITS-1:0] held;
      frame_type          events;
      logic               push;
   } scan_result_type;

   typedef struct packed {
      logic [DIR_W-1:0]   direction;
      logic [EV_BITS-1:0] held;
   } scan_view_type;

   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctrl_type;

   typedef struct packed {
      logic             hit;     // pop found a frame
      logic [CNT_W-1:0] count;   // fill after this request
   } queue_status_type;

endpackage

FILE: design/jkie_scan.sv
// ---------------------------------------------------------------------------
// jkie_scan
// Key debounce, joystick direction with hysteresis, event edges and
// direction auto-repeat for one scan request.
// ---------------------------------------------------------------------------
module jkie_scan (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic [jkie_pkg::ADC_BITS-1:0]         joy_x,
   input  logic [jkie_pkg::ADC_BITS-1:0]         joy_y,
   input  logic [jkie_pkg::KEY_COUNT-1:0]        raw_keys,
   input  logic [jkie_pkg::TIME_W-1:0]           now_ms,
   input  jkie_pkg::cfg_type                     cfg,
   output jkie_pkg::scan_result_type             result,
   output jkie_pkg::scan_view_type               view
);
   import jkie_pkg::*;

   logic [KEY_COUNT-1:0] stable_ff, stable_in;
   logic [KEY_COUNT-1:0] last_raw_ff, last_raw_in;
   logic [DEB_W-1:0]     same_cnt_ff [KEY_COUNT];
   logic [DEB_W-1:0]     same_cnt_in [KEY_COUNT];
   logic [DIR_W-1:0]     dir_ff, dir_in;
   logic [EV_BITS-1:0]   prev_held_ff, held_in;
   logic [DIR_KEYS-1:0]  rpt_ref_ff, rpt_ref_in;
   logic [TIME_W-1:0]    rpt_start_ff, rpt_start_in;
   logic [TIME_W-1:0]    rpt_last_ff, rpt_last_in;

   logic [ADC_BITS-1:0]  xl, xr, yd, yu, dx, dy;
   logic                 still;
   logic [DIR_KEYS-1:0]  dir_bits, rpt_bits;
   logic [TIME_W-1:0]    since_start, since_last;

   // Debounce: count equal samples, saturating at the configured depth
   always_comb begin
      stable_in   = stable_ff;
      last_raw_in = last_raw_ff;
      for (int k = 0; k < KEY_COUNT; k++) begin
         if (raw_keys[k] == last_raw_ff[k]) begin
            same_cnt_in[k] = (same_cnt_ff[k] < cfg.debounce) ?
                             same_cnt_ff[k] + 1'b1 : same_cnt_ff[k];
         end else begin
            last_raw_in[k] = raw_keys[k];
            same_cnt_in[k] = '0;
         end
         if (same_cnt_in[k] >= cfg.debounce) begin
            stable_in[k] = last_raw_in[k];
         end
      end
   end

   // Direction: keep the stored one while its exit test passes
   assign xl = cfg.x_enter[ADC_BITS-1:0];
   assign xr = cfg.x_enter[THR_W-1:ADC_BITS];
   assign yd = cfg.y_enter[ADC_BITS-1:0];
   assign yu = cfg.y_enter[THR_W-1:ADC_BITS];

   always_comb begin
      unique case (dir_ff)
         DIR_LEFT:  still = joy_x < cfg.x_exit[ADC_BITS-1:0];
         DIR_RIGHT: still = joy_x > cfg.x_exit[THR_W-1:ADC_BITS];
         DIR_DOWN:  still = joy_y < cfg.y_exit[ADC_BITS-1:0];
         DIR_UP:    still = joy_y > cfg.y_exit[THR_W-1:ADC_BITS];
         default:   still = 1'b0;
      endcase
   end

   always_comb begin
      dx = '0;
      dy = '0;
      if (joy_x < xl) dx = xl - joy_x;
      else if (joy_x > xr) dx = joy_x - xr;
      if (joy_y < yd) dy = yd - joy_y;
      else if (joy_y > yu) dy = joy_y - yu;
   end

   always_comb begin
      priority if (still) begin
         dir_in = dir_ff;
      end else if (dx == '0 && dy == '0) begin
         dir_in = DIR_CENTER;
      end else if (dx > dy) begin
         dir_in = ((joy_x < xl) ^ cfg.invert[0]) ? DIR_LEFT : DIR_RIGHT;
      end else begin
         dir_in = ((joy_y > yu) ^ cfg.invert[1]) ? DIR_UP : DIR_DOWN;
      end
   end

   always_comb begin
      unique case (dir_in)
         DIR_UP:    dir_bits = 4'b0001;
         DIR_DOWN:  dir_bits = 4'b0010;
         DIR_LEFT:  dir_bits = 4'b0100;
         DIR_RIGHT: dir_bits = 4'b1000;
         default:   dir_bits = '0;
      endcase
   end

   assign held_in = {stable_in, dir_bits};

   // Auto-repeat: restart the timer whenever the held direction set changes
   assign since_start = now_ms - rpt_start_ff;
   assign since_last  = now_ms - rpt_last_ff;

   always_comb begin
      rpt_ref_in   = rpt_ref_ff;
      rpt_start_in = rpt_start_ff;
      rpt_last_in  = rpt_last_ff;
      rpt_bits     = '0;
      priority if (dir_bits == '0) begin
         rpt_ref_in = '0;
      end else if (dir_bits != rpt_ref_ff) begin
         rpt_ref_in   = dir_bits;
         rpt_start_in = now_ms;
         rpt_last_in  = now_ms;
      end else if (since_start < TIME_W'(cfg.rpt_delay)) begin
         rpt_bits = '0;
      end else if (since_last >= TIME_W'(cfg.rpt_interval)) begin
         rpt_last_in = now_ms;
         rpt_bits    = dir_bits;
      end
   end

   always_comb begin
      result.direction        = dir_in;
      result.held             = held_in;
      result.events.pressed   = held_in & ~prev_held_ff;
      result.events.released  = prev_held_ff & ~held_in;
      result.events.repeats   = rpt_bits;
      result.push             = (result.events != '0);
   end

   assign view.direction = dir_ff;
   assign view.held      = prev_held_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff    <= '0;
         last_raw_ff  <= '0;
         dir_ff       <= DIR_CENTER;
         prev_held_ff <= '0;
         rpt_ref_ff   <= '0;
         rpt_start_ff <= '0;
         rpt_last_ff  <= '0;
         for (int k = 0; k < KEY_COUNT; k++) begin
            same_cnt_ff[k] <= '0;
         end
      end else if (advance) begin
         stable_ff    <= stable_in;
         last_raw_ff  <= last_raw_in;
         dir_ff       <= dir_in;
         prev_held_ff <= held_in;
         rpt_ref_ff   <= rpt_ref_in;
         rpt_start_ff <= rpt_start_in;
         rpt_last_ff  <= rpt_last_in;
         for (int k = 0; k < KEY_COUNT; k++) begin
            same_cnt_ff[k] <= same_cnt_in[k];
         end
      end
   end

endmodule

FILE: design/jkie_queue.sv
// ---------------------------------------------------------------------------
// jkie_queue
// Event frame queue: one synchronous memory with head, tail and fill
// pointers; drops the oldest frame when a push finds it full.
// ---------------------------------------------------------------------------
module jkie_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  jkie_pkg::queue_ctrl_type    ctrl,
   input  jkie_pkg::frame_type         wr_frame,
   output jkie_pkg::frame_type         rd_frame,
   output jkie_pkg::queue_status_type  status
);
   import jkie_pkg::*;

   frame_type        mem [QUEUE_DEPTH];
   frame_type        rd_frame_ff;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             full, hit;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full = (fill_ff == CNT_W'(QUEUE_DEPTH));
   assign hit  = ctrl.pop && (fill_ff != '0);

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      priority if (ctrl.push) begin
         tail_in = ptr_next(tail_ff);
         if (full) head_in = ptr_next(head_ff);
         else      fill_in = fill_ff + 1'b1;
      end else if (hit) begin
         head_in = ptr_next(head_ff);
         fill_in = fill_ff - 1'b1;
      end
   end

   assign status.hit   = hit;
   assign status.count = fill_in;
   assign rd_frame     = rd_frame_ff;

   always_ff @(posedge clock) begin
      if (ctrl.push) mem[tail_ff] <= wr_frame;
      if (hit) rd_frame_ff <= mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

endmodule

FILE: design/joystick_key_input_event_unit.sv
// ---------------------------------------------------------------------------
// joystick_key_input_event_unit
// Debounced keys, joystick direction and auto-repeat events with a queue
// of event frames.
// ---------------------------------------------------------------------------
// Use:
//  - req_*: one request a cycle unless rsp_tready stalls. req_tuser selects a scan sample or a
//    dequeue; a scan carries both joystick samples, the raw keys and the
//    millisecond tick in req_tdata.
//  - rsp_*: exactly one response per request, in order. It carries the
//    direction, held bits, the event bits of the scan or of the dequeued
//    frame, and the queue fill after the request; rsp_tuser flags a frame
//    actually taken from the queue.
//  - csr_*: register writes, taken at once; write only while idle.
// Timing: a response appears in the cycle after its request is accepted,
// set by the registered read port of the frame memory. Throughput is one
// request per cycle while rsp_tready is high, also while the response register is refilled.
// Stall: while a response waits with rsp_tready low, the response register and the memory
// read data hold and req_tready drops; nothing is lost.
// Reset: synchronous; registers return to their defaults, the key and
// direction state clears and the queue empties at once (no clearing pass).
// ---------------------------------------------------------------------------
module joystick_key_input_event_unit (
   input  logic                                clock,
   input  logic                                reset,
   // request: joy_x, joy_y, raw_keys, now_ms (from bit 0 up)
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [jkie_pkg::REQ_DATA_W-1:0]     req_tdata,
   // request: op
   input  logic                                req_tuser,
   // response: direction, held keys, pressed keys, released keys,
   //           repeat pulses, queue_count (from bit 0 up)
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [jkie_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // response: frame_valid
   output logic                                rsp_tuser,
   // register writes
   input  logic                                csr_we,
   input  logic [jkie_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [jkie_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import jkie_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   scan_result_type  scan_res;
   scan_view_type    scan_view;
   queue_ctrl_type   q_ctrl;
   queue_status_type q_status;
   frame_type        q_rd_frame;

   logic             accept, is_scan;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [DIR_W-1:0]   rsp_dir_ff;
   logic [EV_BITS-1:0] rsp_held_ff;
   frame_type          rsp_ev_ff;
   logic               rsp_hit_ff;
   logic [CNT_W-1:0]   rsp_count_ff;
   frame_type          rsp_ev;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_X_ENTER:   cfg_in.x_enter      = csr_wdata[THR_W-1:0];
            CSR_Y_ENTER:   cfg_in.y_enter      = csr_wdata[THR_W-1:0];
            CSR_X_EXIT:    cfg_in.x_exit       = csr_wdata[THR_W-1:0];
            CSR_Y_EXIT:    cfg_in.y_exit       = csr_wdata[THR_W-1:0];
            CSR_RPT_DELAY: cfg_in.rpt_delay    = csr_wdata[MS_W-1:0];
            CSR_RPT_INTV:  cfg_in.rpt_interval = csr_wdata[MS_W-1:0];
            CSR_DEBOUNCE:  cfg_in.debounce     = csr_wdata[DEB_W-1:0];
            CSR_INVERT:    cfg_in.invert       = csr_wdata[INV_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_enter      <= ENTER_RST;
         cfg_ff.y_enter      <= ENTER_RST;
         cfg_ff.x_exit       <= EXIT_RST;
         cfg_ff.y_exit       <= EXIT_RST;
         cfg_ff.rpt_delay    <= RPT_DELAY_RST;
         cfg_ff.rpt_interval <= RPT_INTV_RST;
         cfg_ff.debounce     <= DEBOUNCE_RST;
         cfg_ff.invert       <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Take a request whenever the response register is empty or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_scan    = (req_tuser == OP_SCAN);

   jkie_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .advance  (accept && is_scan),
      .joy_x    (req_tdata[REQ_X_LSB +: ADC_BITS]),
      .joy_y    (req_tdata[REQ_Y_LSB +: ADC_BITS]),
      .raw_keys (req_tdata[REQ_KEY_LSB +: KEY_COUNT]),
      .now_ms   (req_tdata[REQ_NOW_LSB +: TIME_W]),
      .cfg      (cfg_ff),
      .result   (scan_res),
      .view     (scan_view)
   );

   // Push only non-empty frames; a dequeue pops when anything is queued
   assign q_ctrl.push = accept && is_scan && scan_res.push;
   assign q_ctrl.pop  = accept && (req_tuser == OP_DEQUEUE);

   jkie_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (q_ctrl),
      .wr_frame (scan_res.events),
      .rd_frame (q_rd_frame),
      .status   (q_status)
   );

   // Response register; dequeued frame data arrives from the memory port
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept)          rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_dir_ff   <= is_scan ? scan_res.direction : scan_view.direction;
         rsp_held_ff  <= is_scan ? scan_res.held : scan_view.held;
         rsp_ev_ff    <= is_scan ? scan_res.events : '0;
         rsp_hit_ff   <= q_status.hit;
         rsp_count_ff <= q_status.count;
      end
   end

   assign rsp_ev     = rsp_hit_ff ? q_rd_frame : rsp_ev_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_count_ff, rsp_ev.repeats, rsp_ev.released,
                                    rsp_ev.pressed, rsp_held_ff, rsp_dir_ff});

   // A stalled response carrying a dequeued frame must keep the frame read
   a_stall_holds_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_hit_ff && !rsp_tready |=> $stable(q_rd_frame))
      else $error("frame read data changed under a stalled response");

   // A dequeue that finds a frame answers next cycle with it and the new fill
   a_dequeue_answers: assert property (@(posedge clock) disable iff (reset)
      accept && q_status.hit |=>
         rsp_tvalid && rsp_tuser && (rsp_count_ff == $past(q_status.count)))
      else $error("dequeue hit not reflected in the response");

   // A dequeue that misses only happens on an empty queue
   a_miss_means_empty: assert property (@(posedge clock) disable iff (reset)
      q_ctrl.pop && !q_status.hit |-> (q_status.count == '0))
      else $error("dequeue missed on a non-empty queue");

endmodule

FILE: sim/tb_joystick_key_input_event_unit.sv
// ---------------------------------------------------------------------------
// tb_joystick_key_input_event_unit
// Self-checking bench for the joystick and key input event unit: directed
// scans at the axis extremes, key debounce, hysteresis and auto-repeat,
// then random scan and dequeue traffic over several register settings with
// random stalls on both streams. A behavioural predictor holds its own copy
// of the key, direction, repeat and queue state and checks every response.
// ---------------------------------------------------------------------------
module tb_joystick_key_input_event_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import jkie_pkg::*;

   // Watchdog: cycles with no request and no response accepted
   localparam int STALL_LIMIT = 4000;

   localparam logic [ADC_BITS-1:0] ADC_MID = 1 << (ADC_BITS - 1);
   localparam logic [ADC_BITS-1:0] ADC_MAX = '1;
   localparam logic [TIME_W-1:0]   WRAP_T0 = 32'hFFFF_FF00;

   // One request as the bench sees it
   typedef struct {
      logic                 op;
      logic [ADC_BITS-1:0]  x;
      logic [ADC_BITS-1:0]  y;
      logic [KEY_COUNT-1:0] keys;
      logic [TIME_W-1:0]    tick;
   } request_type;

   // Response payload, laid out as on rsp_tdata (direction in the lowest bits)
   typedef struct packed {
      logic [CNT_W-1:0]    count;
      logic [DIR_KEYS-1:0] repeats;
      logic [EV_BITS-1:0]  released;
      logic [EV_BITS-1:0]  pressed;
      logic [EV_BITS-1:0]  held;
      logic [DIR_W-1:0]    direction;
   } report_type;

   typedef struct packed {
      logic       taken;   // a frame came out of the queue
      report_type body;
   } expected_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = OP_SCAN;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   joystick_key_input_event_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Predictor state: register copy plus the unit's key, direction, repeat
   // and frame queue state, all starting from their reset values.
   // -------------------------------------------------------------------------
   cfg_type              model_cfg = '{x_enter: ENTER_RST, y_enter: ENTER_RST,
                                       x_exit: EXIT_RST, y_exit: EXIT_RST,
                                       rpt_delay: RPT_DELAY_RST,
                                       rpt_interval: RPT_INTV_RST,
                                       debounce: DEBOUNCE_RST, invert: '0};
   logic [KEY_COUNT-1:0] key_stable = '0;
   logic [KEY_COUNT-1:0] key_last_raw = '0;
   logic [DEB_W-1:0]     key_same_count [KEY_COUNT] = '{default: '0};
   logic [DIR_W-1:0]     current_dir = DIR_CENTER;
   logic [EV_BITS-1:0]   prev_held = '0;
   logic [DIR_KEYS-1:0]  repeat_ref = '0;
   logic [TIME_W-1:0]    rpt_start = '0;
   logic [TIME_W-1:0]    rpt_last = '0;
   frame_type            frame_queue [$];

   expected_type         pending_reports [$];

   int                   send_idle_pct;
   int                   recv_idle_pct;
   logic [TIME_W-1:0]    tick_ms = 32'hFFFF_F000;
   int                   mismatches = 0;
   int                   scan_count = 0;
   int                   dequeue_count = 0;
   int                   pulse_count = 0;
   int                   dropped_frames = 0;
   int                   empty_dequeues = 0;
   int                   settings_loaded = 0;

   // Work out the response to one accepted request and advance the state
   task automatic predict_report(input request_type rq);
      expected_type        want;
      frame_type           fr;
      logic [ADC_BITS-1:0] xl, xr, yd, yu, dx, dy;
      logic [DIR_W-1:0]    dir;
      logic [EV_BITS-1:0]  held, pressed, released;
      logic [DIR_KEYS-1:0] pulse;
      logic [TIME_W-1:0]   since_start, since_last;
      logic                hold_dir;
      int                  k;
      want = '0;
      pressed = '0;
      released = '0;
      pulse = '0;
      if (rq.op == OP_SCAN) begin
         scan_count++;
         // debounce: count equal samples, saturate, follow once the count is met
         for (k = 0; k < KEY_COUNT; k++) begin
            if (rq.keys[k] == key_last_raw[k]) begin
               if (key_same_count[k] < model_cfg.debounce) key_same_count[k]++;
            end else begin
               key_last_raw[k] = rq.keys[k];
               key_same_count[k] = '0;
            end
            if (key_same_count[k] >= model_cfg.debounce) key_stable[k] = key_last_raw[k];
         end
         // hysteresis: keep the stored code while its physical exit test passes
         case (current_dir)
            DIR_LEFT:  hold_dir = rq.x < model_cfg.x_exit[ADC_BITS-1:0];
            DIR_RIGHT: hold_dir = rq.x > model_cfg.x_exit[THR_W-1:ADC_BITS];
            DIR_DOWN:  hold_dir = rq.y < model_cfg.y_exit[ADC_BITS-1:0];
            DIR_UP:    hold_dir = rq.y > model_cfg.y_exit[THR_W-1:ADC_BITS];
            default:   hold_dir = 1'b0;
         endcase
         if (!hold_dir) begin
            xl = model_cfg.x_enter[ADC_BITS-1:0];
            xr = model_cfg.x_enter[THR_W-1:ADC_BITS];
            yd = model_cfg.y_enter[ADC_BITS-1:0];
            yu = model_cfg.y_enter[THR_W-1:ADC_BITS];
            dx = '0;
            dy = '0;
            if (rq.x < xl) dx = xl - rq.x;
            else if (rq.x > xr) dx = rq.x - xr;
            if (rq.y < yd) dy = yd - rq.y;
            else if (rq.y > yu) dy = rq.y - yu;
            if (dx == 0 && dy == 0) begin
               current_dir = DIR_CENTER;
            end else if (dx > dy) begin
               dir = (rq.x < xl) ? DIR_LEFT : DIR_RIGHT;
               if (model_cfg.invert[0]) dir = (dir == DIR_LEFT) ? DIR_RIGHT : DIR_LEFT;
               current_dir = dir;
            end else begin
               // a tie goes to the vertical axis
               dir = (rq.y > yu) ? DIR_UP : DIR_DOWN;
               if (model_cfg.invert[1]) dir = (dir == DIR_UP) ? DIR_DOWN : DIR_UP;
               current_dir = dir;
            end
         end
         held = '0;
         if (current_dir != DIR_CENTER) held[current_dir - 1] = 1'b1;
         held[EV_BITS-1:DIR_KEYS] = key_stable;
         pressed = held & ~prev_held;
         released = prev_held & ~held;
         prev_held = held;
         // auto-repeat: restart the timer whenever the held directions change
         since_start = rq.tick - rpt_start;
         since_last = rq.tick - rpt_last;
         if (held[DIR_KEYS-1:0] == '0) begin
            repeat_ref = '0;
         end else if (held[DIR_KEYS-1:0] != repeat_ref) begin
            repeat_ref = held[DIR_KEYS-1:0];
            rpt_start = rq.tick;
            rpt_last = rq.tick;
         end else if (since_start >= model_cfg.rpt_delay &&
                      since_last >= model_cfg.rpt_interval) begin
            rpt_last = rq.tick;
            pulse = held[DIR_KEYS-1:0];
            pulse_count++;
         end
         if ((pressed | released | pulse) != '0) begin
            // drop the oldest frame when the queue is full
            if (frame_queue.size() >= QUEUE_DEPTH) begin
               void'(frame_queue.pop_front());
               dropped_frames++;
            end
            fr.pressed = pressed;
            fr.released = released;
            fr.repeats = pulse;
            frame_queue.push_back(fr);
         end
      end else begin
         dequeue_count++;
         if (frame_queue.size() > 0) begin
            fr = frame_queue.pop_front();
            pressed = fr.pressed;
            released = fr.released;
            pulse = fr.repeats;
            want.taken = 1'b1;
         end else begin
            empty_dequeues++;
         end
      end
      want.body.direction = current_dir;
      want.body.held = prev_held;
      want.body.pressed = pressed;
      want.body.released = released;
      want.body.repeats = pulse;
      want.body.count = CNT_W'(frame_queue.size());
      pending_reports.push_back(want);
   endtask

   // -------------------------------------------------------------------------
   // Request driver. Idle at random before the request, then hold it until
   // accepted. Nothing is driven after acceptance, so the next call (or the
   // drain) owns req_tvalid in that time step.
   // -------------------------------------------------------------------------
   task automatic send_request(input request_type rq);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= rq.op;
      req_tdata <= REQ_DATA_W'({rq.tick, rq.keys, rq.y, rq.x});
      do @(posedge clock); while (req_tready !== 1'b1);
      predict_report(rq);
   endtask

   function automatic request_type scan_request(input logic [ADC_BITS-1:0] x, y,
                                                input logic [KEY_COUNT-1:0] keys,
                                                input logic [TIME_W-1:0] tick);
      request_type rq;
      rq.op = OP_SCAN;
      rq.x = x;
      rq.y = y;
      rq.keys = keys;
      rq.tick = tick;
      return rq;
   endfunction

   // Dequeue with random content in the fields the unit must ignore
   function automatic request_type dequeue_request();
      request_type rq;
      rq.op = OP_DEQUEUE;
      rq.x = ADC_BITS'($urandom);
      rq.y = ADC_BITS'($urandom);
      rq.keys = KEY_COUNT'($urandom);
      rq.tick = $urandom;
      return rq;
   endfunction

   function automatic cfg_type make_settings(input logic [THR_W-1:0] xe, ye, xo, yo,
                                             input logic [MS_W-1:0] dl, iv,
                                             input logic [DEB_W-1:0] db,
                                             input logic [INV_W-1:0] inv);
      cfg_type s;
      s.x_enter = xe;
      s.y_enter = ye;
      s.x_exit = xo;
      s.y_exit = yo;
      s.rpt_delay = dl;
      s.rpt_interval = iv;
      s.debounce = db;
      s.invert = inv;
      return s;
   endfunction

   // Drop valid and wait until every response is back, then let the unit settle
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write all eight registers back to back; junk above the width of each narrower
   // register must be ignored by the unit.
   task automatic load_settings(input cfg_type s);
      csr_we <= 1'b1;
      csr_index <= CSR_X_ENTER;
      csr_wdata <= s.x_enter;
      @(posedge clock);
      csr_index <= CSR_Y_ENTER;
      csr_wdata <= s.y_enter;
      @(posedge clock);
      csr_index <= CSR_X_EXIT;
      csr_wdata <= s.x_exit;
      @(posedge clock);
      csr_index <= CSR_Y_EXIT;
      csr_wdata <= s.y_exit;
      @(posedge clock);
      csr_index <= CSR_RPT_DELAY;
      csr_wdata <= {(CSR_DATA_W-MS_W)'($urandom), s.rpt_delay};
      @(posedge clock);
      csr_index <= CSR_RPT_INTV;
      csr_wdata <= {(CSR_DATA_W-MS_W)'($urandom), s.rpt_interval};
      @(posedge clock);
      csr_index <= CSR_DEBOUNCE;
      csr_wdata <= {(CSR_DATA_W-DEB_W)'($urandom), s.debounce};
      @(posedge clock);
      csr_index <= CSR_INVERT;
      csr_wdata <= {(CSR_DATA_W-INV_W)'($urandom), s.invert};
      @(posedge clock);
      csr_we <= 1'b0;
      model_cfg = s;
      settings_loaded++;
   endtask

   // -------------------------------------------------------------------------
   // Directed tests, all under the reset register values
   // -------------------------------------------------------------------------

   // Dequeue straight after reset: nothing queued, no frame taken
   task automatic test_empty_dequeue();
      send_request(dequeue_request());
   endtask

   // Each direction at full deflection, hysteresis hold and release, and
   // equal excess on both axes
   task automatic test_axis_extremes();
      send_request(scan_request('0, ADC_MID, '0, 32'd1000));       // left
      send_request(scan_request(12'd1200, ADC_MID, '0, 32'd1001)); // held by exit
      send_request(scan_request(12'd1500, ADC_MID, '0, 32'd1002)); // past exit
      send_request(scan_request(ADC_MAX, ADC_MID, '0, 32'd1003));  // right
      send_request(scan_request(ADC_MID, ADC_MAX, '0, 32'd1004));  // up
      send_request(scan_request(ADC_MID, '0, '0, 32'd1005));       // down
      send_request(scan_request(ADC_MID, ADC_MID, '0, 32'd1006));  // centre
      send_request(scan_request('0, '0, '0, 32'd1007));            // tie, low
      send_request(scan_request(ADC_MAX, ADC_MAX, '0, 32'd1008));  // tie, high
      send_request(scan_request(ADC_MAX, ADC_MID, '0, 32'd1009));  // right
   endtask

   // All keys pressed until stable, then released until stable
   task automatic test_key_debounce();
      repeat (4) send_request(scan_request(ADC_MID, ADC_MID, '1, 32'hFFFF_FFFF));
      repeat (4) send_request(scan_request(ADC_MID, ADC_MID, '0, 32'h8000_0000));
      send_request(dequeue_request());
   endtask

   // Hold up across the tick wrap: first pulse at the start delay, then one
   // each interval, none a millisecond early
   task automatic test_direction_repeat();
      send_request(scan_request(ADC_MID, ADC_MAX, '0, WRAP_T0));
      send_request(scan_request(ADC_MID, ADC_MAX, '0, WRAP_T0 + 32'd399));
      send_request(scan_request(ADC_MID, ADC_MAX, '0, WRAP_T0 + 32'd400));
      send_request(scan_request(ADC_MID, ADC_MAX, '0, WRAP_T0 + 32'd519));
      send_request(scan_request(ADC_MID, ADC_MAX, '0, WRAP_T0 + 32'd520));
   endtask

   // -------------------------------------------------------------------------
   // Random traffic: keys held in runs, some long enough to pass the debounce, with
   // the odd one-scan bounce; the stick parked in a region for a while (deep,
   // centred, on a threshold, or anywhere); the tick mostly creeping forward
   // with occasional long steps and jumps.
   // -------------------------------------------------------------------------
   task automatic test_random_traffic(input int n_items, input int dequeue_pct);
      logic [KEY_COUNT-1:0] keys, raw;
      logic [ADC_BITS-1:0]  x, y, thr;
      logic [THR_W-1:0]     thr_pair;
      logic [2:0]           pick;
      int                   key_run, joy_run, near, i;
      keys = '0;
      x = ADC_MID;
      y = ADC_MID;
      key_run = 0;
      joy_run = 0;
      for (i = 0; i < n_items; i++) begin
         if ($urandom_range(99) < dequeue_pct) begin
            send_request(dequeue_request());
         end else begin
            if (key_run == 0) begin
               key_run = $urandom_range(1) ? $urandom_range(int'(model_cfg.debounce) + 4, 1)
                                           : $urandom_range(4, 1);
               case ($urandom_range(3))
                  0:       keys = KEY_COUNT'($urandom);
                  1:       keys = keys ^ (KEY_COUNT'(1) << $urandom_range(KEY_COUNT - 1));
                  2:       keys = '0;
                  default: keys = '1;
               endcase
            end
            key_run--;
            raw = ($urandom_range(19) == 0) ? KEY_COUNT'($urandom) : keys;
            if (joy_run == 0) begin
               joy_run = $urandom_range(20, 1);
               x = ADC_BITS'($urandom_range(ADC_MID + 200, ADC_MID - 200));
               y = ADC_BITS'($urandom_range(ADC_MID + 200, ADC_MID - 200));
               case ($urandom_range(7))
                  0: ;  // stay near the centre
                  1: x = ADC_BITS'($urandom_range(300, 0));
                  2: x = ADC_BITS'($urandom_range(ADC_MAX, ADC_MAX - 300));
                  3: y = ADC_BITS'($urandom_range(300, 0));
                  4: y = ADC_BITS'($urandom_range(ADC_MAX, ADC_MAX - 300));
                  5: begin
                     // sit within a few counts of one enter or exit threshold
                     pick = 3'($urandom);
                     thr_pair = pick[1] ? (pick[2] ? model_cfg.y_exit : model_cfg.y_enter)
                                        : (pick[2] ? model_cfg.x_exit : model_cfg.x_enter);
                     thr = pick[0] ? thr_pair[THR_W-1:ADC_BITS] : thr_pair[ADC_BITS-1:0];
                     near = int'(thr) + int'($urandom_range(8)) - 4;
                     if (near < 0) near = 0;
                     else if (near > int'(ADC_MAX)) near = int'(ADC_MAX);
                     if (pick[1]) y = ADC_BITS'(near);
                     else x = ADC_BITS'(near);
                  end
                  6: begin
                     x = ADC_BITS'($urandom);
                     y = ADC_BITS'($urandom);
                  end
                  default: begin
                     x = $urandom_range(1) ? ADC_MAX : '0;
                     y = $urandom_range(1) ? ADC_MAX : '0;
                  end
               endcase
            end
            joy_run--;
            case ($urandom_range(19))
               0:       tick_ms = $urandom;
               1, 2:    tick_ms += $urandom_range(70000);
               3, 4, 5: tick_ms += $urandom_range(600);
               default: tick_ms += $urandom_range(40);
            endcase
            send_request(scan_request(x, y, raw, tick_ms));
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Response side: stall at random, compare each accepted response with the
   // oldest expectation, field by field.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic report_mismatch(input string field, input logic [31:0] want, got);
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
   endtask

   always @(posedge clock) begin : check_responses
      report_type   got;
      expected_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         got = report_type'(rsp_tdata[RSP_BITS-1:0]);
         if (pending_reports.size() == 0) begin
            mismatches++;
            $display("%0t: response %h with no request outstanding", $time, rsp_tdata);
         end else begin
            want = pending_reports.pop_front();
            if (got.direction !== want.body.direction)
               report_mismatch("direction", want.body.direction, got.direction);
            if (got.held !== want.body.held)
               report_mismatch("held keys", want.body.held, got.held);
            if (got.pressed !== want.body.pressed)
               report_mismatch("pressed keys", want.body.pressed, got.pressed);
            if (got.released !== want.body.released)
               report_mismatch("released keys", want.body.released, got.released);
            if (got.repeats !== want.body.repeats)
               report_mismatch("repeat pulses", want.body.repeats, got.repeats);
            if (got.count !== want.body.count)
               report_mismatch("queue_count", want.body.count, got.count);
            if (rsp_tuser !== want.taken)
               report_mismatch("frame_valid", want.taken, rsp_tuser);
         end
      end
   end

   // Watchdog: end the run if neither stream moves for too long
   initial begin : watchdog
      int stall_cycles;
      stall_cycles = 0;
      do begin
         @(posedge clock);
         if ((req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end while (stall_cycles < STALL_LIMIT);
      $display("%0t: no request or response accepted for %0d cycles", $time, STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Test sequence. Idling: sender light and receiver heavy first, then the
   // other way round, then none. Registers change only once the unit is idle.
   // -------------------------------------------------------------------------
   initial begin : stimulus
      cfg_type plan [6];
      int      dequeue_pct [6];
      int      phase;
      // extremes low: nearly every sample off-centre, repeat on every scan with an unchanged direction, no debounce
      plan[0] = make_settings('0, '0, '0, '0, '0, '0, '0, 2'd3);
      // extremes high: left or down nearly always, longest delays and debounce
      plan[1] = make_settings('1, '1, '1, '1, '1, '1, '1, 2'd0);
      // wide dead zone, quick repeat; debounce lowered under the saturated counts
      plan[2] = make_settings({12'd3200, 12'd900}, {12'd3100, 12'd1000},
                              {12'd2900, 12'd1200}, {12'd2800, 12'd1300},
                              16'd50, 16'd10, 8'd2, 2'd1);
      plan[3] = make_settings(ENTER_RST, ENTER_RST, EXIT_RST, EXIT_RST,
                              RPT_DELAY_RST, RPT_INTV_RST, 8'd1, 2'd2);
      // hair-trigger stick: enter and exit one count either side of the middle
      plan[4] = make_settings({12'd2049, 12'd2047}, {12'd2049, 12'd2047},
                              {12'd2049, 12'd2047}, {12'd2049, 12'd2047},
                              16'd1, 16'd1, 8'd4, 2'd0);
      plan[5] = make_settings(THR_W'($urandom), THR_W'($urandom),
                              THR_W'($urandom), THR_W'($urandom),
                              MS_W'($urandom_range(300)), MS_W'($urandom_range(100)),
                              DEB_W'($urandom_range(6)), INV_W'($urandom));
      dequeue_pct = '{8, 40, 15, 60, 10, 30};
      send_idle_pct = 19;
      recv_idle_pct = 82;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_empty_dequeue();
      test_axis_extremes();
      test_key_debounce();
      test_direction_repeat();

      for (phase = 0; phase < 6; phase++) begin
         if (phase == 2) begin
            send_idle_pct = 82;
            recv_idle_pct = 19;
         end
         if (phase == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         wait_for_drain();
         load_settings(plan[phase]);
         test_random_traffic(230, dequeue_pct[phase]);
      end

      wait_for_drain();
      repeat (4) @(posedge clock);
      if (pending_reports.size() != 0) begin
         mismatches += pending_reports.size();
         $display("%0t: %0d responses never arrived", $time, pending_reports.size());
      end

      $display("Covered %0d scans and %0d dequeues (%0d on an empty queue) under %0d settings",
               scan_count, dequeue_count, empty_dequeues, settings_loaded + 1);
      $display("with %0d repeat pulses and %0d frames dropped from a full queue",
               pulse_count, dropped_frames);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: files.f
design/jkie_pkg.sv
design/jkie_scan.sv
design/jkie_queue.sv
design/joystick_key_input_event_unit.sv
sim/tb_joystick_key_input_event_unit.sv
